@@ rtl/polygon_halfplane_mask_unit_defines.svh @@
// Assertion macros shared by the checker of polygon_halfplane_mask_unit.
// Expects signals named clk and rst_n in the scope where the macros are used.
`ifndef POLYGON_HALFPLANE_MASK_UNIT_DEFINES_SVH
`define POLYGON_HALFPLANE_MASK_UNIT_DEFINES_SVH

// Same-cycle implication, checked only out of reset.
`define PHM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only out of reset.
`define PHM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/phm_pkg.sv @@
// Shared types and constants of the polygon half-plane mask unit.
// No dependencies; used by every RTL module of the block.
package phm_pkg;

  // Coordinate width of the beat fields and the vertex table.
  localparam int COORD_BITS   = 12;
  localparam int MAX_VERTICES = 8;

  // Widths of the exact cross-product arithmetic.
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  localparam int CROSS_BITS = PROD_BITS + 1;

  // Mode codes of an input beat.
  localparam logic [1:0] MODE_CLEAR    = 2'd0;
  localparam logic [1:0] MODE_APPEND   = 2'd1;
  localparam logic [1:0] MODE_SET_REF  = 2'd2;
  localparam logic [1:0] MODE_CLASSIFY = 2'd3;

  // Mask values.
  localparam logic [7:0] MASK_INSIDE = 8'd255;
  localparam logic [7:0] MASK_OUT    = 8'd0;

  typedef struct packed {
    logic [1:0]            mode;
    logic [COORD_BITS-1:0] coord_x;
    logic [COORD_BITS-1:0] coord_y;
  } in_item_t;

  typedef struct packed {
    logic [7:0] mask_value;
    logic       vertex_overflow;
  } out_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } vertex_t;

  // Tag that travels with one edge through the side-test pipeline.
  typedef struct packed {
    logic vld;
    logic last;
  } edge_tag_t;

endpackage

@@ rtl/phm_edge_test.sv @@
// Two-stage side test of one polygon edge against pixel and reference point.
// Depends on phm_pkg for vertex and tag types and arithmetic widths.
module phm_edge_test (
  input  logic                clk,
  input  logic                rst_n,
  input  phm_pkg::edge_tag_t  in_tag,
  input  phm_pkg::vertex_t    va,
  input  phm_pkg::vertex_t    vb,
  input  phm_pkg::vertex_t    ref_pt,
  input  phm_pkg::vertex_t    pix,
  output phm_pkg::edge_tag_t  out_tag,
  output logic                out_masked
);

  localparam int DB = phm_pkg::DIFF_BITS;
  localparam int PB = phm_pkg::PROD_BITS;
  localparam int XB = phm_pkg::CROSS_BITS;

  logic signed [DB-1:0] dx, dy, rdx, rdy, pdx, pdy;

  logic signed [PB-1:0] ry_dx_r, dy_rx_r, py_dx_r, dy_px_r;
  logic                 dx_zero_r, dx_neg_r;
  logic                 ref_gt_r, pix_lt_r, pix_gt_r;
  phm_pkg::edge_tag_t   tag_r;

  logic signed [XB-1:0] cr, cp;
  logic                 cr_nz, cp_nz, sr_neg, sp_pos, sp_neg, masked;

  phm_pkg::edge_tag_t   out_tag_r;
  logic                 out_masked_r;

  // Differences relative to the edge start, all exact in DIFF_BITS.
  assign dx  = $signed({1'b0, vb.x})     - $signed({1'b0, va.x});
  assign dy  = $signed({1'b0, vb.y})     - $signed({1'b0, va.y});
  assign rdx = $signed({1'b0, ref_pt.x}) - $signed({1'b0, va.x});
  assign rdy = $signed({1'b0, ref_pt.y}) - $signed({1'b0, va.y});
  assign pdx = $signed({1'b0, pix.x})    - $signed({1'b0, va.x});
  assign pdy = $signed({1'b0, pix.y})    - $signed({1'b0, va.y});

  // Stage 1: form the four products and the vertical-edge compares.
  always_ff @(posedge clk) begin
    ry_dx_r   <= PB'(rdy) * PB'(dx);
    dy_rx_r   <= PB'(dy) * PB'(rdx);
    py_dx_r   <= PB'(pdy) * PB'(dx);
    dy_px_r   <= PB'(dy) * PB'(pdx);
    dx_zero_r <= (dx == '0);
    dx_neg_r  <= dx[DB-1];
    ref_gt_r  <= (ref_pt.x > va.x);
    pix_lt_r  <= (pix.x < va.x);
    pix_gt_r  <= (pix.x > va.x);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= in_tag;
    end
  end

  // Stage 2: cross products, signs relative to the edge direction.
  assign cr = $signed({ry_dx_r[PB-1], ry_dx_r}) - $signed({dy_rx_r[PB-1], dy_rx_r});
  assign cp = $signed({py_dx_r[PB-1], py_dx_r}) - $signed({dy_px_r[PB-1], dy_px_r});

  assign cr_nz  = (cr != '0);
  assign cp_nz  = (cp != '0);
  assign sr_neg = cr_nz && (cr[XB-1] ^ dx_neg_r);
  assign sp_pos = cp_nz && !(cp[XB-1] ^ dx_neg_r);
  assign sp_neg = cp_nz && (cp[XB-1] ^ dx_neg_r);

  // Vertical edge compares columns; a sloped edge compares sides of its line.
  always_comb begin
    if (dx_zero_r) begin
      masked = ref_gt_r ? pix_lt_r : pix_gt_r;
    end else begin
      masked = sr_neg ? sp_pos : sp_neg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tag_r <= '0;
    end else begin
      out_tag_r <= tag_r;
    end
  end

  always_ff @(posedge clk) begin
    out_masked_r <= masked;
  end

  assign out_tag    = out_tag_r;
  assign out_masked = out_masked_r;

endmodule

@@ rtl/polygon_halfplane_mask_unit.sv @@
// Polygon half-plane mask unit: vertex memory, edge walk and result register.
// Depends on phm_pkg and instantiates phm_edge_test.
//
// Usage: one input channel (in_valid / in_stall / in_data) carries beats with
// a mode: clear the polygon, append a vertex, set the reference point or
// classify a pixel. Only a classify beat produces a result beat on the output
// channel (out_valid / out_stall / out_data): mask value 255 or 0 and the
// vertex overflow flag.
// Clear, append and set-reference beats leave the unit idle; the next beat can be
// accepted in the following cycle.
// A classify beat with n stored vertices (n >= 2) walks the vertex memory one
// entry per cycle through its single read port, then drains the two-stage
// edge test, with a closing edge from the last vertex back to the first for
// n >= 3. With fewer than two vertices no edge is tested and the unit goes
// straight to its hold state. in_stall is high after the acceptance of a
// classify beat until its result is loaded into the output register.
// The output register lets a new beat be accepted while a result waits; a
// following classify holds its result until the output register frees up.
// Reset (synchronous, rst_n low) empties the polygon, clears the overflow
// flag, sets the reference point to the origin and drops any pending result.
module polygon_halfplane_mask_unit #(
  parameter int MAX_VERTICES = phm_pkg::MAX_VERTICES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  phm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output phm_pkg::out_item_t out_data
);

  localparam int IDX_BITS = $clog2(MAX_VERTICES);
  localparam int CNT_BITS = $clog2(MAX_VERTICES + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_HOLD  = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic                in_acc, is_classify, out_free;
  logic [CNT_BITS-1:0] vcnt_r, cnt_m1;
  logic [IDX_BITS-1:0] last_idx, rd_addr_r;
  logic                few_vtx, two_vtx, tbl_full;
  logic                ovf_r, masked_r;
  phm_pkg::vertex_t    ref_r, pix_r, v0_r, prev_r;

  // Vertex memory and its registered read data.
  phm_pkg::vertex_t    vtab [MAX_VERTICES];
  phm_pkg::vertex_t    rdata_r;
  logic                mem_we, mem_re;
  phm_pkg::vertex_t    wdata;

  // Read-data tracking.
  logic                rd_v_r, rd_first_r, rd_last_r, close_v_r;

  phm_pkg::edge_tag_t  e_in_tag, e_out_tag;
  phm_pkg::vertex_t    e_vb;
  logic                e_masked;

  phm_pkg::out_item_t  out_data_r;
  logic                out_valid_r;

  assign in_acc      = in_valid && !in_stall;
  assign is_classify = (in_data.mode == phm_pkg::MODE_CLASSIFY);
  assign out_free    = !out_valid_r || !out_stall;

  assign cnt_m1   = vcnt_r - CNT_BITS'(1);
  assign last_idx = cnt_m1[IDX_BITS-1:0];
  assign few_vtx  = (vcnt_r < CNT_BITS'(2));
  assign two_vtx  = (vcnt_r == CNT_BITS'(2));
  assign tbl_full = (vcnt_r >= CNT_BITS'(MAX_VERTICES));

  // Next state of the beat sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && is_classify) begin
          state_nxt = few_vtx ? ST_HOLD : ST_WALK;
        end
      end
      ST_WALK: begin
        if (rd_addr_r == last_idx) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (e_out_tag.vld && e_out_tag.last) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

  // Polygon bookkeeping: count, overflow and reference point.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcnt_r <= '0;
      ovf_r  <= 1'b0;
      ref_r  <= '0;
    end else if (in_acc) begin
      unique case (in_data.mode)
        phm_pkg::MODE_CLEAR: begin
          vcnt_r <= '0;
          ovf_r  <= 1'b0;
        end
        phm_pkg::MODE_APPEND: begin
          if (tbl_full) begin
            ovf_r <= 1'b1;
          end else begin
            vcnt_r <= vcnt_r + CNT_BITS'(1);
          end
        end
        phm_pkg::MODE_SET_REF: begin
          ref_r.x <= in_data.coord_x;
          ref_r.y <= in_data.coord_y;
        end
        phm_pkg::MODE_CLASSIFY: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Latch the pixel of a classify beat.
  always_ff @(posedge clk) begin
    if (in_acc && is_classify) begin
      pix_r.x <= in_data.coord_x;
      pix_r.y <= in_data.coord_y;
    end
  end

  // Vertex memory: write on append while the table is not full, one read per cycle during the walk.
  assign mem_we  = in_acc && (in_data.mode == phm_pkg::MODE_APPEND) && !tbl_full;
  assign mem_re  = (state_r == ST_WALK);
  assign wdata.x = in_data.coord_x;
  assign wdata.y = in_data.coord_y;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      vtab[vcnt_r[IDX_BITS-1:0]] <= wdata;
    end
    if (mem_re) begin
      rdata_r <= vtab[rd_addr_r];
    end
  end

  // Advance the read address and tag the returning data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_addr_r  <= '0;
      rd_v_r     <= 1'b0;
      rd_first_r <= 1'b0;
      rd_last_r  <= 1'b0;
      close_v_r  <= 1'b0;
    end else begin
      if (in_acc) begin
        rd_addr_r <= '0;
      end else if (mem_re) begin
        rd_addr_r <= rd_addr_r + IDX_BITS'(1);
      end
      rd_v_r     <= mem_re;
      rd_first_r <= mem_re && (rd_addr_r == '0);
      rd_last_r  <= mem_re && (rd_addr_r == last_idx);
      close_v_r  <= rd_v_r && rd_last_r && !two_vtx;
    end
  end

  // Keep the first vertex for the closing edge and the previous one.
  always_ff @(posedge clk) begin
    if (rd_v_r) begin
      prev_r <= rdata_r;
      if (rd_first_r) begin
        v0_r <= rdata_r;
      end
    end
  end

  // Feed consecutive-vertex edges, then the closing edge when there are more than two vertices.
  assign e_in_tag.vld  = (rd_v_r && !rd_first_r) || close_v_r;
  assign e_in_tag.last = close_v_r || (rd_v_r && rd_last_r && two_vtx);
  assign e_vb          = close_v_r ? v0_r : rdata_r;

  phm_edge_test u_edge (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tag     (e_in_tag),
    .va         (prev_r),
    .vb         (e_vb),
    .ref_pt     (ref_r),
    .pix        (pix_r),
    .out_tag    (e_out_tag),
    .out_masked (e_masked)
  );

  // Accumulate the mask over all edges of the current pixel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      masked_r <= 1'b0;
    end else if (in_acc && is_classify) begin
      masked_r <= 1'b0;
    end else if (e_out_tag.vld) begin
      masked_r <= masked_r | e_masked;
    end
  end

  // Output register: load from hold, drop once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_HOLD) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_HOLD) && out_free) begin
      out_data_r.mask_value      <= masked_r ? phm_pkg::MASK_OUT : phm_pkg::MASK_INSIDE;
      out_data_r.vertex_overflow <= ovf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/phm_checker.sv @@
// Port-level checker of polygon_halfplane_mask_unit, bound to the top level.
// Depends on phm_pkg and the assertion macros in the defines header.
`include "polygon_halfplane_mask_unit_defines.svh"

module phm_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input phm_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input phm_pkg::out_item_t out_data
);

  logic in_acc;
  logic acc_classify;
  logic acc_cmd;
  logic mask_legal;
  logic out_held;

  assign in_acc       = in_valid && !in_stall;
  assign acc_classify = in_acc && (in_data.mode == phm_pkg::MODE_CLASSIFY);
  assign acc_cmd      = in_acc && !acc_classify;
  assign mask_legal   = (out_data.mask_value == phm_pkg::MASK_INSIDE) ||
                        (out_data.mask_value == phm_pkg::MASK_OUT);
  assign out_held     = out_valid && out_stall;

  // A classify beat always leaves the unit busy after its acceptance, stalling the input.
  `PHM_ASSERT_NEXT(a_classify_busy, acc_classify, in_stall, "classify beat not stalled")

  // Non-classify beats leave the input unstalled in the following cycle.
  `PHM_ASSERT_NEXT(a_cmd_one_cycle, acc_cmd, !in_stall, "command beat stalled input")

  // A new result appears only as the unit finishes a classify.
  `PHM_ASSERT_NOW(a_result_from_work, $rose(out_valid), $past(in_stall), "result without work")

  // Mask value is one of the two legal codes.
  `PHM_ASSERT_NOW(a_mask_code, out_valid, mask_legal, "illegal mask value")

  // A stalled result beat holds.
  `PHM_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(out_data), "stalled result changed")

endmodule

bind polygon_halfplane_mask_unit phm_checker u_phm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

@@ bench/phm_mask_checker.sv @@
// Checker for polygon_halfplane_mask_unit: watches both channels, predicts the
// mask of every classify beat and compares the result beats in order.
// Depends on phm_pkg for the beat types, mode codes and mask values.
module phm_mask_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  phm_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  phm_pkg::out_item_t out_data,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the polygon and the reference point
  longint             vert_x [phm_pkg::MAX_VERTICES];
  longint             vert_y [phm_pkg::MAX_VERTICES];
  int                 vert_count;
  longint             anchor_x;
  longint             anchor_y;
  logic               ovf_seen;
  phm_pkg::out_item_t mask_queue [$];

  function automatic int sgn(longint v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  // True if the pixel lies strictly on the far side of the line a -> b.
  function automatic logic edge_cuts(int a, int b, longint px, longint py);
    longint x0, y0, dx, dy;
    int     s_anchor, s_pixel;
    x0 = vert_x[a];
    y0 = vert_y[a];
    dx = vert_x[b] - x0;
    dy = vert_y[b] - y0;
    // Vertical edge: compare columns only
    if (dx == 0) begin
      if (anchor_x > x0) return px < x0;
      return px > x0;
    end
    // Side as the sign of (row - line row), anchor on the line counts as above
    s_anchor = sgn((anchor_y - y0) * dx - dy * (anchor_x - x0)) * sgn(dx);
    s_pixel  = sgn((py - y0) * dx - dy * (px - x0)) * sgn(dx);
    if (s_anchor < 0) return s_pixel > 0;
    return s_pixel < 0;
  endfunction

  function automatic phm_pkg::out_item_t classify_pixel(longint px, longint py);
    int                 n_edges;
    int                 j;
    logic               masked;
    phm_pkg::out_item_t res;
    masked = 1'b0;
    if (vert_count < 2) n_edges = 0;
    else if (vert_count == 2) n_edges = 1;
    else n_edges = vert_count;
    for (int i = 0; i < n_edges; i++) begin
      j = (i + 1 < vert_count) ? i + 1 : 0;
      if (edge_cuts(i, j, px, py)) masked = 1'b1;
    end
    res.mask_value      = masked ? phm_pkg::MASK_OUT : phm_pkg::MASK_INSIDE;
    res.vertex_overflow = ovf_seen;
    return res;
  endfunction

  // Advance the shadow state by one accepted input beat
  task automatic take_beat(phm_pkg::in_item_t b);
    case (b.mode)
      phm_pkg::MODE_CLEAR: begin
        vert_count = 0;
        ovf_seen   = 1'b0;
      end
      phm_pkg::MODE_APPEND: begin
        if (vert_count < phm_pkg::MAX_VERTICES) begin
          vert_x[vert_count] = longint'(b.coord_x);
          vert_y[vert_count] = longint'(b.coord_y);
          vert_count++;
        end else begin
          ovf_seen = 1'b1;
        end
      end
      phm_pkg::MODE_SET_REF: begin
        anchor_x = longint'(b.coord_x);
        anchor_y = longint'(b.coord_y);
      end
      default: begin
        mask_queue = {mask_queue,
                      classify_pixel(longint'(b.coord_x), longint'(b.coord_y))};
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    phm_pkg::out_item_t want;
    if (!rst_n) begin
      vert_count = 0;
      anchor_x   = 0;
      anchor_y   = 0;
      ovf_seen   = 1'b0;
      fail_count = 0;
      mask_queue.delete();
    end else begin
      // Compare a result beat against the oldest prediction
      if (out_valid && !out_stall) begin
        if (mask_queue.size() == 0) begin
          fail_count++;
          $display("%0t ERROR: result beat with none expected: mask %0d ovf %0b",
                   $time, out_data.mask_value, out_data.vertex_overflow);
        end else begin
          want = mask_queue.pop_front();
          if (out_data.mask_value !== want.mask_value) begin
            fail_count++;
            $display("%0t ERROR: mask_value expected %0d actual %0d",
                     $time, want.mask_value, out_data.mask_value);
          end
          if (out_data.vertex_overflow !== want.vertex_overflow) begin
            fail_count++;
            $display("%0t ERROR: vertex_overflow expected %0b actual %0b",
                     $time, want.vertex_overflow, out_data.vertex_overflow);
          end
        end
      end
      if (in_valid && !in_stall) take_beat(in_data);
    end
    pending = mask_queue.size();
  end

endmodule

@@ bench/testbench.sv @@
// Top of the bench for polygon_halfplane_mask_unit: clock, reset, directed beats,
// random beat stimulus in four idling phases and the final verdict.
// Depends on phm_pkg, the unit itself and phm_mask_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1550;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 800000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  phm_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_stall;
  phm_pkg::out_item_t out_data;
  int                 fail_count;
  int                 pending;

  int                 send_idle_pct;
  int                 recv_stall_pct;
  logic               hold_req;
  logic               in_took = 1'b0;
  int                 sent;

  polygon_halfplane_mask_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  phm_mask_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Record input acceptance for the driver to read at the falling edge
  always @(posedge clk) in_took <= in_valid && !in_stall;

  // Receiver: random stall, with one long hold-off on request
  initial begin : receiver
    int   hold_left;
    logic hold_used;
    hold_left = 0;
    hold_used = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_used) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Offer one beat after a random gap and hold it until accepted
  task automatic send_beat(phm_pkg::in_item_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(negedge clk); while (!in_took);
    sent++;
  endtask

  task automatic send(logic [1:0] m, int x, int y);
    phm_pkg::in_item_t b;
    b.mode    = m;
    b.coord_x = phm_pkg::COORD_BITS'(x);
    b.coord_y = phm_pkg::COORD_BITS'(y);
    send_beat(b);
  endtask

  task automatic send_noise();
    send(2'($urandom_range(3)), $urandom_range(4095), $urandom_range(4095));
  endtask

  function automatic int clamp_coord(int v);
    if (v < 0) return 0;
    if (v > 4095) return 4095;
    return v;
  endfunction

  function automatic int near(int c, int r);
    return clamp_coord(c + int'($urandom_range(2 * r)) - r);
  endfunction

  task automatic run_directed();
    // Empty polygon, then a single vertex: everything inside
    send(phm_pkg::MODE_CLASSIFY, 0, 0);
    send(phm_pkg::MODE_APPEND, 0, 0);
    send(phm_pkg::MODE_CLASSIFY, 4095, 0);
    // Single open diagonal edge, anchor above it
    send(phm_pkg::MODE_APPEND, 4095, 4095);
    send(phm_pkg::MODE_SET_REF, 0, 4095);
    send(phm_pkg::MODE_CLASSIFY, 4095, 0);
    send(phm_pkg::MODE_CLASSIFY, 2048, 2048);
    // Anchor on the sloped line counts as the larger-row side
    send(phm_pkg::MODE_SET_REF, 100, 100);
    send(phm_pkg::MODE_CLASSIFY, 10, 0);
    send(phm_pkg::MODE_CLASSIFY, 0, 10);
    // Vertical edge, anchor right of it, then on its column
    send(phm_pkg::MODE_CLEAR, 4095, 4095);
    send(phm_pkg::MODE_APPEND, 100, 0);
    send(phm_pkg::MODE_APPEND, 100, 4095);
    send(phm_pkg::MODE_SET_REF, 200, 5);
    send(phm_pkg::MODE_CLASSIFY, 50, 0);
    send(phm_pkg::MODE_SET_REF, 100, 7);
    send(phm_pkg::MODE_CLASSIFY, 101, 0);
    send(phm_pkg::MODE_CLASSIFY, 99, 4095);
    // Repeated vertices past a full table: overflow, then clear drops it
    send(phm_pkg::MODE_CLEAR, 0, 0);
    repeat (phm_pkg::MAX_VERTICES + 1) send(phm_pkg::MODE_APPEND, 5, 5);
    send(phm_pkg::MODE_CLASSIFY, 6, 6);
    send(phm_pkg::MODE_CLASSIFY, 0, 4095);
    send(phm_pkg::MODE_CLEAR, 0, 0);
    send(phm_pkg::MODE_CLASSIFY, 4095, 4095);
  endtask

  // One polygon: clear, vertices, anchor, pixels; sometimes noise instead
  task automatic send_group();
    int     radius, cx, cy, nv, npx, vx, vy, prev_x, px, py;
    longint sum_x, sum_y;
    if ($urandom_range(99) < 12) begin
      send_noise();
      return;
    end
    case ($urandom_range(3))
      0:       radius = 6;
      1:       radius = 60;
      2:       radius = 600;
      default: radius = 2047;
    endcase
    cx = $urandom_range(4095);
    cy = $urandom_range(4095);
    nv = ($urandom_range(9) == 0) ? $urandom_range(2)
                                  : $urandom_range(3, phm_pkg::MAX_VERTICES + 2);
    send(phm_pkg::MODE_CLEAR, $urandom_range(4095), $urandom_range(4095));
    sum_x  = 0;
    sum_y  = 0;
    prev_x = cx;
    vx     = cx;
    vy     = cy;
    for (int i = 0; i < nv; i++) begin
      vx = near(cx, radius);
      // Reuse the previous column now and then for vertical edges
      if ($urandom_range(5) == 0) vx = prev_x;
      vy = near(cy, radius);
      // Break the sequence once in a while
      if ($urandom_range(99) < 3) send_noise();
      send(phm_pkg::MODE_APPEND, vx, vy);
      sum_x  += vx;
      sum_y  += vy;
      prev_x = vx;
    end
    if (nv > 0 && $urandom_range(9) != 0) begin
      send(phm_pkg::MODE_SET_REF, int'(sum_x / nv), int'(sum_y / nv));
    end else if ($urandom_range(1) == 0) begin
      send(phm_pkg::MODE_SET_REF, $urandom_range(4095), $urandom_range(4095));
    end
    npx = $urandom_range(1, 6);
    for (int i = 0; i < npx; i++) begin
      case ($urandom_range(9))
        0: begin
          px = $urandom_range(4095);
          py = $urandom_range(4095);
        end
        1: begin
          px = vx;
          py = vy;
        end
        default: begin
          px = near(cx, 2 * radius);
          py = near(cy, 2 * radius);
        end
      endcase
      send(phm_pkg::MODE_CLASSIFY, px, py);
    end
  endtask

  initial begin : stimulus
    int base;
    in_valid       = 1'b0;
    in_data        = '0;
    rst_n          = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b0;
    sent           = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    run_directed();
    // Four idling phases over the random beats
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 82;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 82;
        end
        default: begin
          send_idle_pct  = 35;
          recv_stall_pct = 35;
        end
      endcase
      base = sent;
      while (sent - base < RANDOM_ITEMS / 4) begin
        // Start the long receiver hold-off while beats keep coming
        if (ph == 0 && !hold_req && sent - base > 60) hold_req <= 1'b1;
        send_group();
      end
    end
    in_valid <= 1'b0;
    // Drain outstanding results, then let the pipeline settle
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog on total run length
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t ERROR: cycle limit reached with %0d results outstanding", $time, pending);
    $display("status: fail");
    $finish;
  end

endmodule

@@ polygon_halfplane_mask_unit.f @@
+incdir+rtl
rtl/phm_pkg.sv
rtl/phm_edge_test.sv
rtl/polygon_halfplane_mask_unit.sv
rtl/phm_checker.sv
bench/phm_mask_checker.sv
bench/testbench.sv
